// ----- sv/tds_pkg.sv -----
package tds_pkg;

  // Default geometry of the source raster and of the thumbnail
  localparam int SourceStrideDef = 288;
  localparam int LeftMarginDef   = 16;
  localparam int TopRowDef       = 1;
  localparam int ThumbWidthDef   = 64;
  localparam int ThumbHeightDef  = 56;

  // Fixed widths
  localparam int PixelW  = 16;
  localparam int IndexW  = 12;
  localparam int ColW    = 9;
  localparam int RowW    = 8;
  localparam int StoreD  = 64;
  localparam int AddrW   = 6;

  // Averaging masks and repack fields
  localparam logic [PixelW-1:0] Mask565     = 16'hF7DE;
  localparam logic [PixelW-1:0] Mask555     = 16'h7BDE;
  localparam logic [PixelW-1:0] RepackUpper = 16'h7FE0;
  localparam logic [PixelW-1:0] RepackBlue  = 16'h001F;

  // Source format codes
  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB555 = 1'b1
  } format_e;

  // One horizontal average on its way from front to back
  typedef struct packed {
    logic [PixelW-1:0] h_avg;
    logic              is_emit;
    logic [AddrW-1:0]  addr;
    logic [IndexW-1:0] index;
    logic              last;
    format_e           mode;
  } tds_item_t;

  function automatic logic [PixelW-1:0] avg_mask(input format_e mode);
    logic [PixelW-1:0] m;
    case (mode)
      FMT_RGB565: m = Mask565;
      FMT_RGB555: m = Mask555;
      default:    m = Mask565;
    endcase
    return m;
  endfunction

  // Mask and halve each operand, then add
  function automatic logic [PixelW-1:0] half_sum(input logic [PixelW-1:0] a,
                                                 input logic [PixelW-1:0] b,
                                                 input logic [PixelW-1:0] m);
    logic [PixelW-1:0] ha;
    logic [PixelW-1:0] hb;
    ha = (a & m) >> 1;
    hb = (b & m) >> 1;
    return ha + hb;
  endfunction

  // Move red and green up one bit to land in 565 layout
  function automatic logic [PixelW-1:0] repack_565(input logic [PixelW-1:0] v);
    logic [PixelW-1:0] up;
    up = (v & RepackUpper) << 1;
    return up | (v & RepackBlue);
  endfunction

endpackage

// ----- sv/tds_ram.sv -----
module tds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tds_front.sv -----
module tds_front #(
  parameter int SOURCE_STRIDE = tds_pkg::SourceStrideDef,
  parameter int LEFT_MARGIN   = tds_pkg::LeftMarginDef,
  parameter int TOP_ROW       = tds_pkg::TopRowDef,
  parameter int THUMB_WIDTH   = tds_pkg::ThumbWidthDef,
  parameter int THUMB_HEIGHT  = tds_pkg::ThumbHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tds_pkg::PixelW-1:0]  pixel_i,
  input  logic                        frame_start_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output tds_pkg::tds_item_t          push_item_o
);

  import tds_pkg::*;

  format_e           mode_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [PixelW-1:0] held_q, held_d;

  logic              accept;
  logic [ColW-1:0]   col_cur;
  logic [RowW-1:0]   row_cur;
  logic [RowW-1:0]   rr;
  logic [ColW-1:0]   cc;
  logic [RowW-3:0]   j_idx;
  logic [ColW-3:0]   i_idx;
  logic              on_grid;
  logic [IndexW-1:0] index;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Restart the counters on the first pixel of a frame
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;

  // Classify the pixel against the sample grid
  assign rr    = row_cur - RowW'(TOP_ROW);
  assign cc    = col_cur - ColW'(LEFT_MARGIN);
  assign j_idx = rr[RowW-1:2];
  assign i_idx = cc[ColW-1:2];
  assign on_grid = (row_cur >= RowW'(TOP_ROW)) && (col_cur >= ColW'(LEFT_MARGIN)) &&
                   (j_idx < (RowW-2)'(THUMB_HEIGHT)) && (i_idx < (ColW-2)'(THUMB_WIDTH)) &&
                   !rr[1];
  assign index = IndexW'(IndexW'(j_idx) * IndexW'(THUMB_WIDTH)) + IndexW'(i_idx);

  // Build the horizontal average for the queue
  always_comb begin
    push_o                = accept && on_grid && (cc[1:0] == 2'd2);
    push_item_o.h_avg     = half_sum(held_q, pixel_i, avg_mask(mode_q));
    push_item_o.is_emit   = rr[0];
    push_item_o.addr      = i_idx[AddrW-1:0];
    push_item_o.index     = index;
    push_item_o.last      = (index == IndexW'(THUMB_WIDTH * THUMB_HEIGHT - 1));
    push_item_o.mode      = mode_q;
  end

  // Advance counters and capture the left sample
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    held_d = held_q;
    if (accept) begin
      if (on_grid && (cc[1:0] == 2'd0)) begin
        held_d = pixel_i;
      end
      if (col_cur >= ColW'(SOURCE_STRIDE - 1)) begin
        col_d = '0;
        row_d = (row_cur == '1) ? row_cur : row_cur + RowW'(1);
      end else begin
        col_d = col_cur + ColW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FMT_RGB565;
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= format_e'(cfg_wdata_i);
      end
      col_q  <= col_d;
      row_q  <= row_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- sv/tds_queue.sv -----
module tds_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tds_pkg::tds_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output tds_pkg::tds_item_t head_o
);

  import tds_pkg::*;

  tds_item_t   entries_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push;
  logic        do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Move pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- sv/tds_back.sv -----
module tds_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  tds_pkg::tds_item_t          q_head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tds_pkg::PixelW-1:0]  thumb_pixel_o,
  output logic [tds_pkg::IndexW-1:0]  thumb_index_o,
  output logic                        last_o
);

  import tds_pkg::*;

  tds_item_t         s1_item_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] pixel_q;
  logic [IndexW-1:0] index_q;
  logic              last_q;
  logic [PixelW-1:0] rdata;
  logic [PixelW-1:0] v_avg;
  logic [PixelW-1:0] v_out;
  logic              out_free;
  logic              s1_adv;
  logic              s1_free;
  logic              store_wr;
  logic              load_rd;

  // Handshake between queue, read stage and output register
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_adv   = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || s1_adv;
  assign pop_o    = q_valid_i && (!q_head_i.is_emit || s1_free);
  assign store_wr = pop_o && !q_head_i.is_emit;
  assign load_rd  = pop_o && q_head_i.is_emit;

  // Line store of upper-row averages
  tds_ram #(
    .WIDTH (PixelW),
    .DEPTH (StoreD)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_wr),
    .waddr_i (q_head_i.addr),
    .wdata_i (q_head_i.h_avg),
    .re_i    (load_rd),
    .raddr_i (q_head_i.addr),
    .rdata_o (rdata)
  );

  // Vertical average and repack
  always_comb begin
    v_avg = half_sum(rdata, s1_item_q.h_avg, avg_mask(s1_item_q.mode));
    v_out = (s1_item_q.mode == FMT_RGB555) ? repack_565(v_avg) : v_avg;
  end

  always_comb begin
    s1_valid_d  = load_rd ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_rd) begin
      s1_item_q <= q_head_i;
    end
    if (s1_adv) begin
      pixel_q <= v_out;
      index_q <= s1_item_q.index;
      last_q  <= s1_item_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign thumb_pixel_o = pixel_q;
  assign thumb_index_o = index_q;
  assign last_o        = last_q;

endmodule

// ----- sv/thumbnail_downscale_4x.sv -----
// Channel   Handshake                   Payload
// config    cfg_we_i                    cfg_wdata_i (format_mode)
// input     in_valid_i / in_ready_o     pixel_i, frame_start_i
// output    out_valid_o / out_ready_i   thumb_pixel_o, thumb_index_o, last_o
//
// One source pixel is taken per cycle while in_ready_o is high; a thumbnail pixel leaves
// after its lower-row half passes the queue, line store read and output register.
// The line store has one write and one read port, so its reads never collide.
// Reset (rst_ni, async, active low) clears counters, held sample and handshake
// state; the line store is not cleared and is always written before it is read.
// An output stall fills the read stage and the two-entry queue before in_ready_o drops.
module thumbnail_downscale_4x #(
  parameter int SOURCE_STRIDE = tds_pkg::SourceStrideDef,
  parameter int LEFT_MARGIN   = tds_pkg::LeftMarginDef,
  parameter int TOP_ROW       = tds_pkg::TopRowDef,
  parameter int THUMB_WIDTH   = tds_pkg::ThumbWidthDef,
  parameter int THUMB_HEIGHT  = tds_pkg::ThumbHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tds_pkg::PixelW-1:0]  pixel_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tds_pkg::PixelW-1:0]  thumb_pixel_o,
  output logic [tds_pkg::IndexW-1:0]  thumb_index_o,
  output logic                        last_o
);

  import tds_pkg::*;

  tds_item_t push_item;
  tds_item_t head_item;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;

  // Counters, grid classification, horizontal average
  tds_front #(
    .SOURCE_STRIDE (SOURCE_STRIDE),
    .LEFT_MARGIN   (LEFT_MARGIN),
    .TOP_ROW       (TOP_ROW),
    .THUMB_WIDTH   (THUMB_WIDTH),
    .THUMB_HEIGHT  (THUMB_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // Decouple front from back
  tds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  // Line store, vertical average, output register
  tds_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .thumb_pixel_o (thumb_pixel_o),
    .thumb_index_o (thumb_index_o),
    .last_o        (last_o)
  );

endmodule

// ----- tb/thumb_pixel_checker.sv -----
`timescale 1ns / 1ps

module thumb_pixel_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [tds_pkg::PixelW-1:0]  pixel_i,
  input  logic                        frame_start_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [tds_pkg::PixelW-1:0]  thumb_pixel_i,
  input  logic [tds_pkg::IndexW-1:0]  thumb_index_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  import tds_pkg::*;

  localparam int LastIndex = ThumbWidthDef * ThumbHeightDef - 1;

  typedef struct packed {
    logic [PixelW-1:0] pix;
    logic [IndexW-1:0] index;
    logic              last;
  } thumb_t;

  // Thumbnail pixels predicted but not yet seen on the output
  thumb_t            pending_thumbs[$];

  // Own copy of the block state
  format_e           fmt;
  logic [ColW-1:0]   col_cnt;
  logic [RowW-1:0]   row_cnt;
  logic [PixelW-1:0] held_px;
  logic [PixelW-1:0] line_avg [StoreD];
  int                errors;

  // Drop the low bit of each channel, halve both and add
  function automatic logic [PixelW-1:0] blend_pair(input logic [PixelW-1:0] a,
                                                   input logic [PixelW-1:0] b,
                                                   input logic [PixelW-1:0] msk);
    logic [PixelW-1:0] sum;
    sum = ((a & msk) >> 1) + ((b & msk) >> 1);
    return sum;
  endfunction

  // Advance the predictor by one source pixel, queue a thumbnail pixel if one completes
  task automatic predict_source_pixel(input logic [PixelW-1:0] px, input logic fs);
    logic [PixelW-1:0] msk;
    logic [PixelW-1:0] h;
    logic [PixelW-1:0] v;
    int                rr;
    int                cc;
    int                j;
    int                i;
    thumb_t            t;
    if (fs) begin
      col_cnt = '0;
      row_cnt = '0;
    end
    msk = (fmt == FMT_RGB555) ? Mask555 : Mask565;
    rr  = int'(row_cnt) - TopRowDef;
    cc  = int'(col_cnt) - LeftMarginDef;
    if (rr >= 0 && cc >= 0 && rr / 4 < ThumbHeightDef && cc / 4 < ThumbWidthDef &&
        rr % 4 <= 1) begin
      j = rr / 4;
      i = cc / 4;
      if (cc % 4 == 0) begin
        held_px = px;
      end else if (cc % 4 == 2) begin
        h = blend_pair(held_px, px, msk);
        if (rr % 4 == 0) begin
          line_avg[i] = h;
        end else begin
          v = blend_pair(line_avg[i], h, msk);
          // 555 sources move red and green up one bit
          if (fmt == FMT_RGB555) begin
            v = ((v & RepackUpper) << 1) | (v & RepackBlue);
          end
          t.pix   = v;
          t.index = IndexW'(j * ThumbWidthDef + i);
          t.last  = (j * ThumbWidthDef + i == LastIndex);
          pending_thumbs.push_back(t);
        end
      end
    end
    // Wrap the column at the end of the row, saturate the row
    if (col_cnt >= ColW'(SourceStrideDef - 1)) begin
      col_cnt = '0;
      if (row_cnt != '1) begin
        row_cnt = row_cnt + RowW'(1);
      end
    end else begin
      col_cnt = col_cnt + ColW'(1);
    end
  endtask

  task automatic check_thumb();
    thumb_t want;
    if (pending_thumbs.size() == 0) begin
      errors++;
      $error("thumb_index: no result expected, got %0d", thumb_index_i);
    end else begin
      want = pending_thumbs.pop_front();
      if (thumb_pixel_i !== want.pix) begin
        errors++;
        $error("thumb_pixel: expected %h, got %h", want.pix, thumb_pixel_i);
      end
      if (thumb_index_i !== want.index) begin
        errors++;
        $error("thumb_index: expected %0d, got %0d", want.index, thumb_index_i);
      end
      if (last_i !== want.last) begin
        errors++;
        $error("last: expected %b, got %b", want.last, last_i);
      end
    end
  endtask

  // Compare results first, then predict, then apply a register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt     = FMT_RGB565;
      col_cnt = '0;
      row_cnt = '0;
      held_px = '0;
      errors  = 0;
      pending_thumbs.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_thumb();
      end
      if (in_valid_i && in_ready_i) begin
        predict_source_pixel(pixel_i, frame_start_i);
      end
      if (cfg_we_i) begin
        fmt = format_e'(cfg_wdata_i);
      end
      fail_count_o <= errors;
      pending_o    <= pending_thumbs.size();
    end
  end

endmodule

// ----- tb/thumbnail_downscale_4x_tb.sv -----
`timescale 1ns / 1ps

module thumbnail_downscale_4x_tb;
  import tds_pkg::*;

  localparam int CycleLimit  = 4_000_000;
  localparam int DrainCycles = 6;
  localparam int RandomItems = 40;
  localparam int Stride      = SourceStrideDef;
  localparam int EmitCols    = 120;
  localparam int FlipCol     = 64;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_wdata_i   = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [PixelW-1:0] pixel_i       = '0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [PixelW-1:0] thumb_pixel_o;
  logic [IndexW-1:0] thumb_index_o;
  logic              last_o;

  int                fail_count;
  int                pending_cnt;
  int                cycle_cnt    = 0;
  int                burst_left   = 0;
  int                rx_left      = 0;
  logic              rx_open      = 1'b0;
  format_e           cur_fmt      = FMT_RGB565;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  thumbnail_downscale_4x u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .thumb_pixel_o (thumb_pixel_o),
    .thumb_index_o (thumb_index_o),
    .last_o        (last_o)
  );

  thumb_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .thumb_pixel_i (thumb_pixel_o),
    .thumb_index_i (thumb_index_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_cnt)
  );

  // Receiver: alternate open runs and stalls, with an occasional long open run
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_open = !rx_open;
      if (rx_open) begin
        rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 24);
      end else begin
        rx_left = $urandom_range(1, 10);
      end
    end
    rx_left--;
    out_ready_i <= rx_open;
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("thumbnail_downscale_4x: mismatch");
      $finish;
    end
  end

  function automatic logic [PixelW-1:0] random_pixel();
    logic [PixelW-1:0] px;
    case ($urandom_range(0, 7))
      0:       px = '0;
      1:       px = '1;
      default: px = PixelW'($urandom);
    endcase
    return px;
  endfunction

  // Sampled pairs per thumbnail column: all ones, all zeros, ones over zeros, random
  function automatic logic [PixelW-1:0] pattern_pixel(input int k);
    logic [PixelW-1:0] px;
    int                col;
    int                row;
    col = k % Stride;
    row = k / Stride;
    case ((col / 4) % 4)
      0:       px = '1;
      1:       px = '0;
      2:       px = (row % 2 == 1) ? '1 : '0;
      default: px = random_pixel();
    endcase
    return px;
  endfunction

  // Offer one pixel, possibly idling first when the current burst is used up
  task automatic send_pixel(input logic [PixelW-1:0] px, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500)
                                               : $urandom_range(1, 40);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  // Hold input, wait for every expected pixel, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_format(input format_e f);
    cfg_wdata_i <= f;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_fmt = f;
  endtask

  // One frame of len pixels; at pixel cut the block is drained and the format flipped
  task automatic send_frame(input int len, input int cut, input bit patterned);
    for (int k = 0; k < len; k++) begin
      if (k == cut) begin
        drain();
        write_format(cur_fmt == FMT_RGB565 ? FMT_RGB555 : FMT_RGB565);
      end
      send_pixel(patterned ? pattern_pixel(k) : random_pixel(), k == 0);
    end
  endtask

  initial begin
    int len;
    int cut;
    int rand_items;
    rand_items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_format(FMT_RGB565);

    // Directed: truncated frame, then a patterned frame that emits in 565 and
    // flips to 555 partway along the first emitting row
    send_frame(20, -1, 1'b1);
    send_frame(2 * Stride + EmitCols, 2 * Stride + FlipCol, 1'b1);

    // Random short frames, with format writes between some of them
    while (rand_items < RandomItems) begin
      len = $urandom_range(1, 30);
      cut = (len > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, len - 1) : -1;
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_format(format_e'($urandom_range(0, 1)));
      end
      send_frame(len, cut, 1'b0);
      rand_items += len;
    end

    drain();
    if (fail_count == 0) begin
      $display("thumbnail_downscale_4x: match");
    end else begin
      $display("thumbnail_downscale_4x: mismatch");
    end
    $finish;
  end

endmodule
